[rtl/core/osse_pkg.sv]
// Shared constants, field widths and decoded item kinds for the makespan evaluator.
`default_nettype none
package osse_pkg;

  localparam int FUNC_W  = 2;
  localparam int JOB_W   = 4;
  localparam int MACH_W  = 4;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 32;
  // Wide enough to compare a field against any index limit up to 256
  localparam int IDX_W   = 9;

  localparam int DEF_MAX_JOBS     = 16;
  localparam int DEF_MAX_MACHINES = 16;
  localparam int DEF_TIME_BITS    = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // What the back end does with a queued beat
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_OP,
    KIND_CLEAR
  } kind_t;

endpackage
`default_nettype wire

[rtl/core/osse_if.sv]
// Valid/ready channel interfaces for the item input and the result output.
`default_nettype none
interface osse_in_if;
  logic                          valid;
  logic                          ready;
  logic [osse_pkg::FUNC_W-1:0]   func;
  logic [osse_pkg::JOB_W-1:0]    job;
  logic [osse_pkg::MACH_W-1:0]   machine;
  logic [osse_pkg::JOB_W-1:0]    prev_job;
  logic [osse_pkg::VAL_W-1:0]    setup_value;

  modport source (output valid, func, job, machine, prev_job, setup_value, input ready);
  modport sink   (input valid, func, job, machine, prev_job, setup_value, output ready);
endinterface

interface osse_out_if;
  logic                        valid;
  logic                        ready;
  logic [osse_pkg::OUT_W-1:0]  end_time;
  logic [osse_pkg::OUT_W-1:0]  makespan;
  logic                        saturated;

  modport source (output valid, end_time, makespan, saturated, input ready);
  modport sink   (input valid, end_time, makespan, saturated, output ready);
endinterface
`default_nettype wire

[rtl/core/open_shop_setup_makespan_evaluator.sv]
// Top level of the open-shop makespan evaluator with sequence-dependent setup times.
//
// in_ch carries one beat per item: func selects a setup-table load, a scheduled
// operation (job, machine) or a schedule clear. out_ch returns exactly one beat
// per item: the operation's end time (zero for other items), the running
// makespan and a flag set when the end time clipped at full scale.
// An accepted beat is decoded into a two-entry queue, read from the queue into
// the issue stage (predecessor lookup, setup table read), then resolved in the
// execute stage into the result register. One item per cycle is sustained while
// out_ch is ready; the setup table's single read port and the registered
// ready-time update in the execute stage set that rate.
// Reset clears ready times, predecessor marks and the makespan;
// the setup table keeps whatever it held and must be loaded before use.
// When out_ch stalls, the result register, the execute stage and the two-entry
// queue hold up to four beats in all before in_ch.ready drops.
`default_nettype none
module open_shop_setup_makespan_evaluator #(
  parameter int MAX_JOBS     = osse_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = osse_pkg::DEF_MAX_MACHINES,
  parameter int TIME_BITS    = osse_pkg::DEF_TIME_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  osse_in_if.sink      in_ch,
  osse_out_if.source   out_ch
);

  localparam int JW = $clog2(MAX_JOBS);
  localparam int MW = $clog2(MAX_MACHINES);
  localparam int AW = $clog2(MAX_JOBS * MAX_MACHINES * MAX_JOBS);

  logic                        q_valid;
  osse_pkg::kind_t             q_kind;
  logic [JW-1:0]               q_job;
  logic [MW-1:0]               q_mach;
  logic [JW-1:0]               q_prev;
  logic [osse_pkg::VAL_W-1:0]  q_val;
  logic [AW-1:0]               q_base;
  logic                        pop;

  osse_front #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .pop     (pop),
    .q_valid (q_valid),
    .q_kind  (q_kind),
    .q_job   (q_job),
    .q_mach  (q_mach),
    .q_prev  (q_prev),
    .q_val   (q_val),
    .q_base  (q_base)
  );

  osse_back #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_kind  (q_kind),
    .q_job   (q_job),
    .q_mach  (q_mach),
    .q_prev  (q_prev),
    .q_val   (q_val),
    .q_base  (q_base),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/osse_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module osse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/core/osse_front.sv]
// Front end: range-checks and decodes input beats and queues them for the back end.
`default_nettype none
module osse_front #(
  parameter int MAX_JOBS     = osse_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = osse_pkg::DEF_MAX_MACHINES,
  localparam int JW = $clog2(MAX_JOBS),
  localparam int MW = $clog2(MAX_MACHINES),
  localparam int AW = $clog2(MAX_JOBS * MAX_MACHINES * MAX_JOBS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  osse_in_if.sink                            in_ch,
  input  wire logic                          pop,
  output logic                               q_valid,
  output osse_pkg::kind_t                    q_kind,
  output logic [JW-1:0]                      q_job,
  output logic [MW-1:0]                      q_mach,
  output logic [JW-1:0]                      q_prev,
  output logic [osse_pkg::VAL_W-1:0]         q_val,
  output logic [AW-1:0]                      q_base
);

  localparam int QD = 2;
  localparam int IW = osse_pkg::IDX_W;

  logic [IW-1:0]    job_x, mach_x, prev_x;
  logic             job_ok, mach_ok, prev_ok;
  osse_pkg::kind_t  kind_c;
  logic [JW-1:0]    job_c, prev_c;
  logic [MW-1:0]    mach_c;
  logic [AW-1:0]    base_c;
  logic             push;

  osse_pkg::kind_t             kind_q_r [QD];
  logic [JW-1:0]               job_q_r  [QD];
  logic [MW-1:0]               mach_q_r [QD];
  logic [JW-1:0]               prev_q_r [QD];
  logic [osse_pkg::VAL_W-1:0]  val_q_r  [QD];
  logic [AW-1:0]               base_q_r [QD];
  logic                        wr_ptr_r, rd_ptr_r;
  logic [1:0]                  cnt_r, cnt_nxt;

  assign job_x   = IW'(in_ch.job);
  assign mach_x  = IW'(in_ch.machine);
  assign prev_x  = IW'(in_ch.prev_job);
  assign job_ok  = job_x  < IW'(MAX_JOBS);
  assign mach_ok = mach_x < IW'(MAX_MACHINES);
  assign prev_ok = prev_x < IW'(MAX_JOBS);

  assign job_c  = job_x[JW-1:0];
  assign mach_c = mach_x[MW-1:0];
  assign prev_c = prev_x[JW-1:0];
  // Row base of the (job, machine) block; the predecessor is added later
  assign base_c = (AW'(job_c) * AW'(MAX_MACHINES) + AW'(mach_c)) * AW'(MAX_JOBS);

  always_comb begin
    unique case (in_ch.func)
      osse_pkg::FUNC_LOAD:
        kind_c = (job_ok && mach_ok && prev_ok) ? osse_pkg::KIND_LOAD : osse_pkg::KIND_NOP;
      osse_pkg::FUNC_SCHED:
        kind_c = (job_ok && mach_ok) ? osse_pkg::KIND_OP : osse_pkg::KIND_NOP;
      osse_pkg::FUNC_CLEAR:
        kind_c = osse_pkg::KIND_CLEAR;
      default:
        kind_c = osse_pkg::KIND_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(QD));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q_r[wr_ptr_r] <= kind_c;
      job_q_r[wr_ptr_r]  <= job_c;
      mach_q_r[wr_ptr_r] <= mach_c;
      prev_q_r[wr_ptr_r] <= prev_c;
      val_q_r[wr_ptr_r]  <= in_ch.setup_value;
      base_q_r[wr_ptr_r] <= base_c;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_kind  = kind_q_r[rd_ptr_r];
  assign q_job   = job_q_r[rd_ptr_r];
  assign q_mach  = mach_q_r[rd_ptr_r];
  assign q_prev  = prev_q_r[rd_ptr_r];
  assign q_val   = val_q_r[rd_ptr_r];
  assign q_base  = base_q_r[rd_ptr_r];

endmodule
`default_nettype wire

[rtl/core/osse_back.sv]
// Back end: setup table access, ready-time update and the result register.
`default_nettype none
module osse_back #(
  parameter int MAX_JOBS     = osse_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = osse_pkg::DEF_MAX_MACHINES,
  parameter int TIME_BITS    = osse_pkg::DEF_TIME_BITS,
  localparam int JW = $clog2(MAX_JOBS),
  localparam int MW = $clog2(MAX_MACHINES),
  localparam int AW = $clog2(MAX_JOBS * MAX_MACHINES * MAX_JOBS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire osse_pkg::kind_t               q_kind,
  input  wire logic [JW-1:0]                 q_job,
  input  wire logic [MW-1:0]                 q_mach,
  input  wire logic [JW-1:0]                 q_prev,
  input  wire logic [osse_pkg::VAL_W-1:0]    q_val,
  input  wire logic [AW-1:0]                 q_base,
  output logic                               pop,
  osse_out_if.source                         out_ch
);

  localparam int TW    = TIME_BITS;
  localparam int OW    = osse_pkg::OUT_W;
  localparam int DEPTH = MAX_JOBS * MAX_MACHINES * MAX_JOBS;

  // Issue stage: predecessor bookkeeping and table port
  logic                  last_valid_r [MAX_MACHINES];
  logic [JW-1:0]         last_job_r   [MAX_MACHINES];
  logic [JW-1:0]         pred_c;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [osse_pkg::VAL_W-1:0] ram_rdata;

  // Execute stage
  logic                  s1_v_r;
  osse_pkg::kind_t       s1_kind_r;
  logic [JW-1:0]         s1_job_r;
  logic [MW-1:0]         s1_mach_r;
  logic                  adv;

  logic [TW-1:0]         mach_ready_r [MAX_MACHINES];
  logic [TW-1:0]         job_ready_r  [MAX_JOBS];
  logic [TW-1:0]         makespan_r;
  logic [TW-1:0]         start_c, end_c, makespan_nxt;
  logic [TW:0]           sum_c;
  logic                  sat_c;

  // Result register
  logic                  out_v_r;
  logic [TW-1:0]         out_end_r, out_ms_r;
  logic                  out_sat_r;
  logic [TW-1:0]         out_end_nxt;
  logic                  out_sat_nxt;
  logic [TW+OW-1:0]      end_ext, ms_ext;

  assign adv = s1_v_r && (!out_v_r || out_ch.ready);
  assign pop = q_valid && (!s1_v_r || adv);

  assign pred_c    = last_valid_r[q_mach] ? last_job_r[q_mach] : q_job;
  assign ram_we    = pop && (q_kind == osse_pkg::KIND_LOAD);
  assign ram_waddr = q_base + AW'(q_prev);
  assign ram_re    = pop && (q_kind == osse_pkg::KIND_OP);
  assign ram_raddr = q_base + AW'(pred_c);

  osse_ram #(
    .WIDTH (osse_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Predecessor state is owned by the issue stage, so it needs no forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MACHINES; i++) begin
        last_valid_r[i] <= 1'b0;
      end
    end else if (pop) begin
      if (q_kind == osse_pkg::KIND_CLEAR) begin
        for (int i = 0; i < MAX_MACHINES; i++) begin
          last_valid_r[i] <= 1'b0;
        end
      end else if (q_kind == osse_pkg::KIND_OP) begin
        last_valid_r[q_mach] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_kind == osse_pkg::KIND_OP) begin
      last_job_r[q_mach] <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pop) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r <= q_kind;
      s1_job_r  <= q_job;
      s1_mach_r <= q_mach;
    end
  end

  // Start at the later ready time, add the setup, clip at full scale
  always_comb begin
    start_c = (mach_ready_r[s1_mach_r] > job_ready_r[s1_job_r]) ?
              mach_ready_r[s1_mach_r] : job_ready_r[s1_job_r];
    sum_c   = {1'b0, start_c} + (TW+1)'(ram_rdata);
    sat_c   = sum_c[TW];
    end_c   = sat_c ? '1 : sum_c[TW-1:0];
  end

  always_comb begin
    out_end_nxt  = '0;
    out_sat_nxt  = 1'b0;
    makespan_nxt = makespan_r;
    unique case (s1_kind_r)
      osse_pkg::KIND_OP: begin
        out_end_nxt  = end_c;
        out_sat_nxt  = sat_c;
        makespan_nxt = (end_c > makespan_r) ? end_c : makespan_r;
      end
      osse_pkg::KIND_CLEAR: begin
        makespan_nxt = '0;
      end
      default: begin
        makespan_nxt = makespan_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      makespan_r <= '0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
        mach_ready_r[i] <= '0;
      end
      for (int i = 0; i < MAX_JOBS; i++) begin
        job_ready_r[i] <= '0;
      end
    end else if (adv) begin
      makespan_r <= makespan_nxt;
      if (s1_kind_r == osse_pkg::KIND_CLEAR) begin
        for (int i = 0; i < MAX_MACHINES; i++) begin
          mach_ready_r[i] <= '0;
        end
        for (int i = 0; i < MAX_JOBS; i++) begin
          job_ready_r[i] <= '0;
        end
      end else if (s1_kind_r == osse_pkg::KIND_OP) begin
        mach_ready_r[s1_mach_r] <= end_c;
        job_ready_r[s1_job_r]   <= end_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_end_r <= out_end_nxt;
      out_ms_r  <= makespan_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  // Report the low word of the times, zero-filled when times are narrower
  assign end_ext = {{OW{1'b0}}, out_end_r};
  assign ms_ext  = {{OW{1'b0}}, out_ms_r};

  assign out_ch.valid     = out_v_r;
  assign out_ch.end_time  = end_ext[OW-1:0];
  assign out_ch.makespan  = ms_ext[OW-1:0];
  assign out_ch.saturated = out_sat_r;

endmodule
`default_nettype wire
